FILE: rtl/core/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared definitions for the inverse Legendre search
// Widths of the operands and the wide search values, and the sequencer states.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Width of the prime and exponent operands.
  localparam int OPERAND_BITS = 32;
  // Width of trial values, bounds and counts (holds prime times exponent).
  localparam int WIDE_BITS    = 2 * OPERAND_BITS;
  // Width of the divider's step counter.
  localparam int STEP_BITS    = $clog2(WIDE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_EVAL,
    S_DIV
  } ils_state_t;

endpackage

FILE: rtl/core/inverse_legendre_search.sv
// ----------------------------------------------------------------------------
// inverse_legendre_search: least n whose factorial holds a prime power
// Bisects on n and counts factors with Legendre's formula on a shared divider.
// ----------------------------------------------------------------------------
// An item (prime p, exponent e) is taken when start is high and busy is low.
// The block answers with the smallest n for which p^e divides n!, shown on
// out_least_n for exactly one cycle with out_valid high; the receiver cannot
// stall, so the result must be captured in that cycle. A prime below two is
// answered with zero in the cycle after it is taken, without going busy. Otherwise
// the block bisects between p and p*e, and for each trial value it forms the
// Legendre count by dividing repeatedly by p on one restoring divider that
// yields one quotient bit per cycle. The number of bisection steps plus the
// final check is at most about WIDE_BITS, and a trial value needs at most one
// division more than log_p of that value, fewer when the count reaches e early.
// With p = 2 and the largest exponent, both numbers are about 34; larger primes
// need far fewer divisions per trial.
module inverse_legendre_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ils_pkg::OPERAND_BITS-1:0] in_prime,
  input  logic [ils_pkg::OPERAND_BITS-1:0] in_exponent,
  output logic                             out_valid,
  output logic [ils_pkg::WIDE_BITS-1:0]    out_least_n
);

  localparam int OB = ils_pkg::OPERAND_BITS;
  localparam int WB = ils_pkg::WIDE_BITS;

  ils_pkg::ils_state_t state_r, state_nxt;

  // Operands of the item in work.
  logic [OB-1:0] p_r, p_nxt;
  logic [OB-1:0] e_r, e_nxt;
  // Bisection bounds, the trial value, the running quotient and the count.
  logic [WB-1:0] low_r, low_nxt;
  logic [WB-1:0] high_r, high_nxt;
  logic [WB-1:0] n_r, n_nxt;
  logic [WB-1:0] q_r, q_nxt;
  logic [WB-1:0] sum_r, sum_nxt;
  // High while the count belongs to the final check of the low bound.
  logic          final_r, final_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WB-1:0] least_n_r, least_n_nxt;

  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [WB-1:0] div_quot;

  logic [WB-1:0] prod;
  logic [WB:0]   low_plus2;
  logic [WB:0]   mid_sum;
  logic          keep_going;
  logic          qualifies;

  ils_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_r),
    .divisor  (p_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // The upper bound is prime times exponent; a single 32 by 32 product.
  assign prod = WB'(p_r) * WB'(e_r);

  // The search goes on while the bounds are at least two apart.
  assign low_plus2  = {1'b0, low_r} + (WB + 1)'(2);
  assign keep_going = {1'b0, high_r} >= low_plus2;
  assign mid_sum    = {1'b0, low_r} + {1'b0, high_r};

  // The count only grows, so it can stop as soon as it reaches the exponent.
  assign qualifies = sum_r >= {{(WB - OB){1'b0}}, e_r};

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    e_nxt         = e_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    n_nxt         = n_r;
    q_nxt         = q_r;
    sum_nxt       = sum_r;
    final_nxt     = final_r;
    out_valid_nxt = 1'b0;
    least_n_nxt   = least_n_r;
    div_start     = 1'b0;

    unique case (state_r)
      ils_pkg::S_IDLE: begin
        if (start) begin
          if (in_prime < OB'(2)) begin
            // A base of zero or one has no meaning; the answer is zero.
            out_valid_nxt = 1'b1;
            least_n_nxt   = '0;
          end else begin
            p_nxt     = in_prime;
            e_nxt     = in_exponent;
            state_nxt = ils_pkg::S_MUL;
          end
        end
      end

      ils_pkg::S_MUL: begin
        low_nxt   = {{(WB - OB){1'b0}}, p_r};
        high_nxt  = prod;
        state_nxt = ils_pkg::S_CHECK;
      end

      ils_pkg::S_CHECK: begin
        sum_nxt   = '0;
        state_nxt = ils_pkg::S_EVAL;
        if (keep_going) begin
          // Midpoint of the bounds; the sum carries one extra bit.
          n_nxt     = mid_sum[WB:1];
          q_nxt     = mid_sum[WB:1];
          final_nxt = 1'b0;
        end else begin
          n_nxt     = low_r;
          q_nxt     = low_r;
          final_nxt = 1'b1;
        end
      end

      ils_pkg::S_EVAL: begin
        if (qualifies || q_r == '0) begin
          if (final_r) begin
            out_valid_nxt = 1'b1;
            least_n_nxt   = qualifies ? low_r : high_r;
            state_nxt     = ils_pkg::S_IDLE;
          end else begin
            if (qualifies) begin
              high_nxt = n_r;
            end else begin
              low_nxt = n_r;
            end
            state_nxt = ils_pkg::S_CHECK;
          end
        end else begin
          // Next term of the formula: the previous quotient divided by p.
          div_start = 1'b1;
          state_nxt = ils_pkg::S_DIV;
        end
      end

      ils_pkg::S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quot;
          sum_nxt   = sum_r + div_quot;
          state_nxt = ils_pkg::S_EVAL;
        end
      end

      default: begin
        state_nxt = ils_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ils_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r       <= p_nxt;
    e_r       <= e_nxt;
    low_r     <= low_nxt;
    high_r    <= high_nxt;
    n_r       <= n_nxt;
    q_r       <= q_nxt;
    sum_r     <= sum_nxt;
    final_r   <= final_nxt;
    least_n_r <= least_n_nxt;
  end

  assign busy        = (state_r != ils_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_least_n = least_n_r;

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("division started while the divider is busy");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ils_pkg::S_EVAL) |-> sum_r <= n_r)
    else $error("Legendre count exceeds the trial value");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ils_pkg::S_IDLE)
    else $error("result shown while an item is still in work");

endmodule

FILE: rtl/core/ils_div.sv
// ----------------------------------------------------------------------------
// ils_div: shared restoring divider
// Divides a wide dividend by an operand-width divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ils_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ils_pkg::WIDE_BITS-1:0]    dividend,
  input  logic [ils_pkg::OPERAND_BITS-1:0] divisor,
  output logic                             busy,
  output logic                             done,
  output logic [ils_pkg::WIDE_BITS-1:0]    quotient
);

  localparam int OB = ils_pkg::OPERAND_BITS;
  localparam int WB = ils_pkg::WIDE_BITS;
  localparam int SB = ils_pkg::STEP_BITS;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SB-1:0] cnt_r, cnt_nxt;
  logic [WB-1:0] acc_r, acc_nxt;
  logic [OB-1:0] rem_r, rem_nxt;
  logic [OB-1:0] div_r, div_nxt;

  logic [OB:0]   rem_sh;
  logic [OB:0]   rem_diff;
  logic          fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign rem_sh   = {rem_r, acc_r[WB-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign fits     = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SB'(WB - 1);
      acc_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      acc_nxt = {acc_r[WB-2:0], fits};
      rem_nxt = fits ? rem_diff[OB-1:0] : rem_sh[OB-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = acc_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reports done while still busy");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0) |=> done_r)
    else $error("divider finished its last step without done");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && div_r != '0) |-> rem_r < div_r)
    else $error("partial remainder reached the divisor");

endmodule
